[rtl/mhpq_pkg.sv]
`timescale 1ns / 1ps

package mhpq_pkg;

   localparam int HEAP_DEPTH_DEFAULT = 64;
   localparam int VALUE_W            = 32;
   localparam int STATUS_W           = 2;
   localparam int COUNT_OUT_W        = 7;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_ROOT,
      ST_DN_LAST,
      ST_DN_L,
      ST_DN_R,
      ST_DN_CMP,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [VALUE_W-1:0]     max_value;
      logic [COUNT_OUT_W-1:0] count_after;
   } result_type;

endpackage

[rtl/max_heap_priority_queue.sv]
`timescale 1ns / 1ps
// Binary max-heap in a single one-read/one-write RAM, one operation at a time.
// Insert: the value climbs one level per parent read and compare (UP_RD, UP_CMP).
// Remove: root and last entry are fetched, then the hole sinks one level per
// child read and compare (DN_L/DN_R, DN_CMP). Full/empty refusals go to ST_RESP.
// The result sits in an output register, so a new beat is taken while it waits.
// Reset clears the entry count and control; RAM contents are left as they are.

module max_heap_priority_queue import mhpq_pkg::*; #(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_kind,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_max_value,
   output logic [COUNT_OUT_W-1:0]     rsp_count_after
);

   localparam int IdxW = $clog2(HEAP_DEPTH);

   logic               res_valid, res_take;
   result_type         res;
   logic               ram_wr_en, ram_rd_en;
   logic [IdxW-1:0]    ram_wr_addr, ram_rd_addr;
   logic [VALUE_W-1:0] ram_wr_data, ram_rd_data;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   mhpq_engine #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_kind    (req_kind),
      .req_value   (req_value),
      .req_stall   (req_stall),
      .res_valid   (res_valid),
      .res         (res),
      .res_take    (res_take),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   mhpq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (HEAP_DEPTH)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // output register is free when empty or being drained this cycle
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_data_ff.status;
   assign rsp_max_value   = rsp_data_ff.max_value;
   assign rsp_count_after = rsp_data_ff.count_after;

endmodule

[rtl/mhpq_ram.sv]
`timescale 1ns / 1ps

module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mhpq_engine.sv]
`timescale 1ns / 1ps

module mhpq_engine import mhpq_pkg::*; #(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEFAULT,
   localparam int IdxW = $clog2(HEAP_DEPTH)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_kind,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      req_stall,
   output logic                      res_valid,
   output result_type                res,
   input  logic                      res_take,
   output logic                      ram_wr_en,
   output logic [IdxW-1:0]           ram_wr_addr,
   output logic [VALUE_W-1:0]        ram_wr_data,
   output logic                      ram_rd_en,
   output logic [IdxW-1:0]           ram_rd_addr,
   input  logic [VALUE_W-1:0]        ram_rd_data
);

   localparam int CntW    = $clog2(HEAP_DEPTH + 1);
   localparam int ChW     = IdxW + 2;
   localparam int CntExtW = (CntW > COUNT_OUT_W) ? CntW : COUNT_OUT_W;

   state_type state_ff, state_in;
   logic [CntW-1:0]           count_ff, count_in;
   logic [IdxW-1:0]           hole_ff, hole_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic [VALUE_W-1:0]        ldata_ff, ldata_in;
   logic [VALUE_W-1:0]        max_ff, max_in;
   logic [STATUS_W-1:0]       status_ff, status_in;

   logic               accept, is_full, is_empty, hole_zero, up_swap;
   logic [IdxW-1:0]    parent;
   logic [ChW-1:0]     cnt_ext, l_idx, r_idx, nl_idx;
   logic               l_ok, r_ok, nl_ok, take_r, take_l, dn_move;
   logic signed [VALUE_W-1:0] best_val;
   logic [IdxW-1:0]    child;
   logic [VALUE_W-1:0] child_data;
   logic [CntExtW-1:0] count_ext;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_full   = (count_ff >= CntW'(HEAP_DEPTH));
   assign is_empty  = (count_ff == '0);
   assign hole_zero = (hole_ff == '0);
   assign parent    = IdxW'((hole_ff - 1'b1) >> 1);
   assign up_swap   = (val_ff > $signed(ram_rd_data));

   // children of the hole: 2h+1 and 2h+2
   assign cnt_ext = ChW'(count_ff);
   assign l_idx   = {1'b0, hole_ff, 1'b1};
   assign r_idx   = l_idx + 1'b1;
   assign l_ok    = (l_idx < cnt_ext);
   assign r_ok    = (r_idx < cnt_ext);

   // right child wins a tie: left must beat it strictly
   assign take_r     = r_ok && ($signed(ram_rd_data) > val_ff);
   assign best_val   = take_r ? $signed(ram_rd_data) : val_ff;
   assign take_l     = ($signed(ldata_ff) > best_val);
   assign dn_move    = take_r || take_l;
   assign child      = take_l ? IdxW'(l_idx) : IdxW'(r_idx);
   assign child_data = take_l ? ldata_ff : ram_rd_data;
   assign nl_idx     = {1'b0, child, 1'b1};
   assign nl_ok      = (nl_idx < cnt_ext);

   assign count_ext = CntExtW'(count_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_INSERT) begin
                  state_in = is_full ? ST_RESP : ST_UP_RD;
               end else begin
                  state_in = is_empty ? ST_RESP : ST_DN_ROOT;
               end
            end
         end
         ST_UP_RD:   state_in = hole_zero ? ST_RESP : ST_UP_CMP;
         ST_UP_CMP:  state_in = up_swap ? ST_UP_RD : ST_RESP;
         ST_DN_ROOT: state_in = ST_DN_LAST;
         ST_DN_LAST: state_in = is_empty ? ST_RESP : ST_DN_L;
         ST_DN_L:    state_in = l_ok ? ST_DN_R : ST_RESP;
         ST_DN_R:    state_in = ST_DN_CMP;
         ST_DN_CMP: begin
            if (!dn_move) begin
               state_in = ST_RESP;
            end else begin
               state_in = nl_ok ? ST_DN_R : ST_DN_L;
            end
         end
         ST_RESP:    state_in = res_take ? ST_IDLE : ST_RESP;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in    = count_ff;
      hole_in     = hole_ff;
      val_in      = val_ff;
      ldata_in    = ldata_ff;
      max_in      = max_ff;
      status_in   = status_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = hole_ff;
      ram_wr_data = val_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = l_idx[IdxW-1:0];
      res_valid   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               max_in = '0;
               if (req_kind == KIND_INSERT) begin
                  if (is_full) begin
                     status_in = STAT_FULL;
                  end else begin
                     status_in = STAT_OK;
                     hole_in   = IdxW'(count_ff);
                     val_in    = req_value;
                     count_in  = count_ff + 1'b1;
                  end
               end else begin
                  if (is_empty) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     status_in   = STAT_OK;
                     count_in    = count_ff - 1'b1;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                  end
               end
            end
         end
         ST_UP_RD: begin
            if (hole_zero) begin
               ram_wr_en = 1'b1;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = parent;
            end
         end
         ST_UP_CMP: begin
            ram_wr_en = 1'b1;
            if (up_swap) begin
               ram_wr_data = ram_rd_data;
               hole_in     = parent;
            end
         end
         ST_DN_ROOT: begin
            max_in      = ram_rd_data;
            ram_rd_en   = 1'b1;
            ram_rd_addr = IdxW'(count_ff);   // last entry, count already lowered
         end
         ST_DN_LAST: begin
            val_in  = ram_rd_data;
            hole_in = '0;
         end
         ST_DN_L: begin
            if (l_ok) begin
               ram_rd_en = 1'b1;
            end else begin
               ram_wr_en = 1'b1;
            end
         end
         ST_DN_R: begin
            ldata_in    = ram_rd_data;
            ram_rd_en   = r_ok;
            ram_rd_addr = r_idx[IdxW-1:0];
         end
         ST_DN_CMP: begin
            ram_wr_en = 1'b1;
            if (dn_move) begin
               ram_wr_data = child_data;
               hole_in     = child;
               ram_rd_en   = nl_ok;
               ram_rd_addr = nl_idx[IdxW-1:0];
            end
         end
         ST_RESP: begin
            res_valid = 1'b1;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   assign res.status      = status_ff;
   assign res.max_value   = max_ff;
   assign res.count_after = count_ext[COUNT_OUT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      hole_ff   <= hole_in;
      val_ff    <= val_in;
      ldata_ff  <= ldata_in;
      max_ff    <= max_in;
      status_ff <= status_in;
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
   import mhpq_pkg::*;

   localparam int DEPTH        = HEAP_DEPTH_DEFAULT;
   localparam int ITEM_TARGET  = 900;
   localparam int QUIET_TAIL   = 120;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct {
      logic                      kind;
      logic signed [VALUE_W-1:0] value;
   } heap_op_type;

   typedef enum int {SEG_FILL, SEG_DRAIN, SEG_GROW, SEG_SHRINK} segment_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_kind = KIND_INSERT;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_max_value;
   logic [COUNT_OUT_W-1:0]    rsp_count_after;

   heap_op_type pending_ops[$];
   result_type  expected_rsps[$];

   // shadow copy of the heap
   logic signed [VALUE_W-1:0] shadow_heap[DEPTH];
   int                        shadow_count = 0;

   int fail_count = 0;
   int idle_left  = 0;
   int stall_left = 0;
   int cycle_count = 0;
   int n_insert = 0, n_remove = 0, n_full = 0, n_empty = 0, peak_count = 0;

   max_heap_priority_queue #(.HEAP_DEPTH(DEPTH)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_max_value   (rsp_max_value),
      .rsp_count_after (rsp_count_after)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic result_type heap_apply(input logic kind,
                                              input logic signed [VALUE_W-1:0] value);
      result_type                res;
      int                        pos, up, lc, rc, best;
      logic signed [VALUE_W-1:0] tmp;
      res.status    = STAT_OK;
      res.max_value = '0;
      if (kind == KIND_INSERT) begin
         n_insert++;
         if (shadow_count >= DEPTH) begin
            res.status = STAT_FULL;
            n_full++;
         end else begin
            pos = shadow_count;
            shadow_heap[pos] = value;
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (shadow_heap[pos] > shadow_heap[up]) begin
                  tmp = shadow_heap[pos];
                  shadow_heap[pos] = shadow_heap[up];
                  shadow_heap[up] = tmp;
               end
               pos = up;
            end
            shadow_count++;
            if (shadow_count > peak_count) peak_count = shadow_count;
         end
      end else begin
         n_remove++;
         if (shadow_count == 0) begin
            res.status = STAT_EMPTY;
            n_empty++;
         end else begin
            res.max_value = shadow_heap[0];
            shadow_heap[0] = shadow_heap[shadow_count - 1];
            shadow_count--;
            pos = 0;
            while (pos < shadow_count) begin
               lc = 2 * pos + 1;
               rc = lc + 1;
               best = pos;
               // right child checked first so a tie between children goes right
               if (rc < shadow_count && shadow_heap[rc] > shadow_heap[best]) best = rc;
               if (lc < shadow_count && shadow_heap[lc] > shadow_heap[best]) best = lc;
               if (best == pos) break;
               tmp = shadow_heap[pos];
               shadow_heap[pos] = shadow_heap[best];
               shadow_heap[best] = tmp;
               pos = best;
            end
         end
      end
      res.count_after = COUNT_OUT_W'(shadow_count);
      return res;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2: return VALUE_W'(int'($urandom_range(0, 7)) - 4);
         3:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_op(input logic kind, input logic signed [VALUE_W-1:0] value);
      heap_op_type op;
      op.kind  = kind;
      op.value = value;
      pending_ops.push_back(op);
   endtask

   // driver: presents the next pending beat, with short idle bursts
   always @(posedge clock) begin : drive_proc
      heap_op_type nxt;
      bit          take;
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = 0;
      end else begin
         take = !req_valid || !req_stall;
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(heap_apply(req_kind, req_value));
            if (pending_ops.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
               idle_left = $urandom_range(1, 3);
         end
         if (take) begin
            if (idle_left > 0 || pending_ops.size() == 0) begin
               if (idle_left > 0) idle_left--;
               req_valid <= 1'b0;
            end else begin
               nxt = pending_ops.pop_front();
               req_valid <= 1'b1;
               req_kind  <= nxt.kind;
               req_value <= nxt.value;
            end
         end
      end
   end

   // monitor: checks each result beat and stalls in short bursts
   always @(posedge clock) begin : check_proc
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("result beat with nothing expected: status %0d max_value %0d count %0d",
                      rsp_status, rsp_max_value, rsp_count_after);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_max_value !== $signed(want.max_value)) begin
                  $error("max_value: expected %0d, got %0d",
                         $signed(want.max_value), rsp_max_value);
                  fail_count++;
               end
               if (rsp_count_after !== want.count_after) begin
                  $error("count_after: expected %0d, got %0d",
                         want.count_after, rsp_count_after);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (pending_ops.size() > QUIET_TAIL && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_rsps.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stim_proc
      segment_type seg;
      int          n;

      // directed: empty remove, extremes, duplicates, drain past empty
      queue_op(KIND_REMOVE, 32'sh1234_5678);
      queue_op(KIND_INSERT, 32'sh7FFF_FFFF);
      queue_op(KIND_INSERT, 32'sh8000_0000);
      queue_op(KIND_INSERT, 32'sh0);
      queue_op(KIND_INSERT, -32'sh1);
      repeat (4) queue_op(KIND_INSERT, 32'sh5);
      queue_op(KIND_INSERT, 32'sh1);
      repeat (11) queue_op(KIND_REMOVE, $urandom);

      while (pending_ops.size() < ITEM_TARGET) begin
         seg = segment_type'($urandom_range(0, 3));
         case (seg)
            SEG_FILL: begin
               n = DEPTH + $urandom_range(1, 6);
               repeat (n) queue_op(KIND_INSERT, pick_value());
            end
            SEG_DRAIN: begin
               n = DEPTH + $urandom_range(1, 6);
               repeat (n) queue_op(KIND_REMOVE, $urandom);
            end
            SEG_GROW: begin
               repeat (40) queue_op(($urandom_range(0, 9) < 3) ? KIND_REMOVE : KIND_INSERT,
                                    pick_value());
            end
            default: begin
               repeat (40) queue_op(($urandom_range(0, 9) < 6) ? KIND_REMOVE : KIND_INSERT,
                                    pick_value());
            end
         endcase
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d inserts (%0d refused as full) and %0d removes (%0d on empty heap)",
               n_insert, n_full, n_remove, n_empty);
      $display("Peak occupancy %0d of %0d entries, %0d mismatches", peak_count, DEPTH,
               fail_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[files.f]
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/mhpq_engine.sv
rtl/max_heap_priority_queue.sv
tb/tb.sv
